// ===== rtl/bpf_pkg.sv =====
// ---------------------------------------------------------------------------
// bpf_pkg: shared types and constants of the bezier path flattener
// Datapath command codes, status bundle, segment kinds and register map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpf_pkg;

   // default build values
   localparam int MAX_SEG_POINTS_DEF = 64;
   localparam int COORD_BITS_DEF     = 16;

   // configuration port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [7:0] SPACING_RESET = 8'd8;

   // segment kinds
   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_LINE  = 2'd1,
      FUNC_QUAD  = 2'd2,
      FUNC_CUBIC = 2'd3
   } func_type;

   // register indexes
   typedef enum logic [2:0] {
      REG_SPACING  = 3'd0,
      REG_CLIP_EN  = 3'd1,
      REG_CLIP_XLO = 3'd2,
      REG_CLIP_XHI = 3'd3,
      REG_CLIP_YLO = 3'd4,
      REG_CLIP_YHI = 3'd5,
      REG_RSVD6    = 3'd6,
      REG_RSVD7    = 3'd7
   } reg_index_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_GEOM,
      OP_DIV,
      OP_MSET,
      OP_DEN1,
      OP_DEN2,
      OP_PTA,
      OP_PTB,
      OP_MAC,
      OP_PREP,
      OP_QBIT,
      OP_EMIT_PT,
      OP_EMIT_END,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] sel;   // control point index for geometry and mac steps
   } cmd_type;

   typedef struct packed {
      logic is_cubic;
      logic cull;
      logic div_done;
      logic pt_more;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/bpf_ctrl.sv =====
// ---------------------------------------------------------------------------
// bpf_ctrl: segment sequencer
// Steps the datapath through geometry, point count, weights, division
// and vertex emission, one segment at a time; lines only emit the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpf_ctrl #(
   parameter int COORD_BITS = bpf_pkg::COORD_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [1:0]          req_func,
   input  wire bpf_pkg::status_type status,
   output bpf_pkg::cmd_type         cmd
);
   import bpf_pkg::*;

   localparam int JW = $clog2(COORD_BITS);

   typedef enum logic [3:0] {
      S_IDLE, S_GEOM, S_CULL, S_DIV, S_MSET, S_DEN1, S_DEN2, S_PTA,
      S_PTB, S_MAC, S_PREP, S_QBIT, S_EMPT, S_EMEND, S_FLUSH
   } state_type;

   state_type        state_ff;
   logic [1:0]       k_ff;
   logic [JW-1:0]    j_ff;

   assign req_tready = (state_ff == S_IDLE);

   // command decode
   always_comb begin
      cmd.op  = OP_NONE;
      cmd.sel = k_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid) cmd.op = OP_LOAD;
         S_GEOM:  cmd.op = OP_GEOM;
         S_CULL:  cmd.op = OP_NONE;
         S_DIV:   cmd.op = OP_DIV;
         S_MSET:  cmd.op = OP_MSET;
         S_DEN1:  cmd.op = OP_DEN1;
         S_DEN2:  cmd.op = OP_DEN2;
         S_PTA:   cmd.op = OP_PTA;
         S_PTB:   cmd.op = OP_PTB;
         S_MAC:   cmd.op = OP_MAC;
         S_PREP:  cmd.op = OP_PREP;
         S_QBIT:  cmd.op = OP_QBIT;
         S_EMPT:  if (status.out_free) cmd.op = OP_EMIT_PT;
         S_EMEND: if (status.out_free) cmd.op = OP_EMIT_END;
         S_FLUSH: if (status.out_free) cmd.op = OP_FLUSH;
         default: cmd.op = OP_NONE;
      endcase
   end

   // state and step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         j_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               k_ff <= 2'd1;
               if (req_func == FUNC_START || req_func == FUNC_LINE) state_ff <= S_EMEND;
               else state_ff <= S_GEOM;
            end
            S_GEOM: begin
               if (k_ff == (status.is_cubic ? 2'd3 : 2'd2)) state_ff <= S_CULL;
               k_ff <= k_ff + 2'd1;
            end
            S_CULL:  state_ff <= status.cull ? S_EMEND : S_DIV;
            S_DIV:   if (status.div_done) state_ff <= S_MSET;
            S_MSET:  state_ff <= S_DEN1;
            S_DEN1:  state_ff <= S_DEN2;
            S_DEN2:  state_ff <= S_PTA;
            S_PTA:   state_ff <= S_PTB;
            S_PTB: begin
               k_ff     <= 2'd0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) state_ff <= S_PREP;
            end
            S_PREP: begin
               j_ff     <= JW'(COORD_BITS - 1);
               state_ff <= S_QBIT;
            end
            S_QBIT: begin
               j_ff <= j_ff - 1'b1;
               if (j_ff == '0) state_ff <= S_EMPT;
            end
            S_EMPT:  if (status.out_free) state_ff <= status.pt_more ? S_PTA : S_EMEND;
            S_EMEND: if (status.out_free) state_ff <= S_FLUSH;
            S_FLUSH: if (status.out_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // the division walks exactly one step per quotient bit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREP) |=> (state_ff == S_QBIT && j_ff == JW'(COORD_BITS - 1)))
      else $error("quotient bit count not loaded");

   // an item is only taken while idle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("sequencer did not start on accepted word");

   // curve work is only entered for curve kinds
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_tvalid && req_func == FUNC_LINE) |=> (state_ff == S_EMEND))
      else $error("line segment entered curve path");

endmodule

`default_nettype wire

// ===== rtl/bpf_datapath.sv =====
// ---------------------------------------------------------------------------
// bpf_datapath: flattener arithmetic and output staging
// Segment registers, length and bounding box, point count, Bernstein
// weights, rounding divider, duplicate filter and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpf_datapath #(
   parameter int MAX_SEG_POINTS = bpf_pkg::MAX_SEG_POINTS_DEF,
   parameter int COORD_BITS     = bpf_pkg::COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bpf_pkg::cmd_type             cmd,
   output bpf_pkg::status_type               status,
   input  wire logic [1:0]                   in_func,
   input  wire logic signed [COORD_BITS-1:0] in_c1x,
   input  wire logic signed [COORD_BITS-1:0] in_c1y,
   input  wire logic signed [COORD_BITS-1:0] in_c2x,
   input  wire logic signed [COORD_BITS-1:0] in_c2y,
   input  wire logic signed [COORD_BITS-1:0] in_ex,
   input  wire logic signed [COORD_BITS-1:0] in_ey,
   input  wire logic [7:0]                   cfg_spacing,
   input  wire logic                         cfg_clip_en,
   input  wire logic signed [COORD_BITS-1:0] cfg_xlo,
   input  wire logic signed [COORD_BITS-1:0] cfg_xhi,
   input  wire logic signed [COORD_BITS-1:0] cfg_ylo,
   input  wire logic signed [COORD_BITS-1:0] cfg_yhi,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [COORD_BITS-1:0]      out_x,
   output logic signed [COORD_BITS-1:0]      out_y,
   output logic                              out_last
);
   import bpf_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int IW = $clog2(MAX_SEG_POINTS);
   localparam int CW = $clog2(MAX_SEG_POINTS + 1);
   localparam int WW = 3 * IW;
   localparam int AW = WW + CB;
   localparam int NW = AW + 2;
   localparam int LW = CB + 3;

   typedef logic signed [CB-1:0] crd_type;

   // segment registers
   logic [1:0] func_ff;
   crd_type    p0x_ff, p0y_ff, p1x_ff, p1y_ff, p2x_ff, p2y_ff, ex_ff, ey_ff;
   crd_type    bx_lo_ff, bx_hi_ff, by_lo_ff, by_hi_ff;
   logic [LW-1:0] len_ff;
   logic [CW-1:0] q_ff;
   logic [IW-1:0] m_ff, i_ff;
   logic [2*IW-1:0] sq_ff, ss_ff, st_ff, tt_ff;
   logic [WW-1:0] den_ff;
   logic [WW-1:0] w_ff [4];
   logic [AW-1:0] accx_ff, accy_ff;
   logic [NW-1:0] rx_ff, ry_ff, dsh_ff;
   logic [CB-1:0] qx_ff, qy_ff;
   crd_type    pen_x_ff, pen_y_ff, pend_x_ff, pend_y_ff, out_x_ff, out_y_ff;
   logic       pen_valid_ff, pend_valid_ff, out_valid_ff, out_last_ff;

   logic       cubic;
   assign cubic = (func_ff == FUNC_CUBIC);

   // control point k of the current curve, quadratics use the end twice
   function automatic crd_type pt_x(input logic [1:0] k);
      crd_type r;
      unique case (k)
         2'd0: r = p0x_ff;
         2'd1: r = p1x_ff;
         2'd2: r = cubic ? p2x_ff : ex_ff;
         default: r = ex_ff;
      endcase
      return r;
   endfunction

   function automatic crd_type pt_y(input logic [1:0] k);
      crd_type r;
      unique case (k)
         2'd0: r = p0y_ff;
         2'd1: r = p1y_ff;
         2'd2: r = cubic ? p2y_ff : ey_ff;
         default: r = ey_ff;
      endcase
      return r;
   endfunction

   function automatic logic [CB-1:0] absdiff(input crd_type a, input crd_type b);
      logic signed [CB:0] d;
      d = {a[CB-1], a} - {b[CB-1], b};
      return d[CB] ? CB'(-d) : CB'(d);
   endfunction

   // geometry step terms
   crd_type cur_x, cur_y, prv_x, prv_y;
   logic [LW-1:0] len_add;
   assign cur_x = pt_x(cmd.sel);
   assign cur_y = pt_y(cmd.sel);
   assign prv_x = pt_x(cmd.sel - 2'd1);
   assign prv_y = pt_y(cmd.sel - 2'd1);
   assign len_add = LW'(absdiff(cur_x, prv_x)) + LW'(absdiff(cur_y, prv_y));

   // point count by repeated subtraction, saturating at the maximum
   logic div_done;
   assign div_done = (q_ff == CW'(MAX_SEG_POINTS)) || (len_ff < LW'(cfg_spacing));

   // weight terms, s = m - i and t = i
   logic [IW-1:0] s_v;
   assign s_v = m_ff - i_ff;

   // mac products on offset-binary coordinates
   crd_type mx, my;
   logic [CB-1:0] ux, uy;
   logic [AW-1:0] prodx, prody;
   assign mx = pt_x(cmd.sel);
   assign my = pt_y(cmd.sel);
   assign ux = {~mx[CB-1], mx[CB-2:0]};
   assign uy = {~my[CB-1], my[CB-2:0]};
   assign prodx = AW'(w_ff[cmd.sel]) * AW'(ux);
   assign prody = AW'(w_ff[cmd.sel]) * AW'(uy);

   // divider compare
   logic gex, gey;
   assign gex = (rx_ff >= dsh_ff);
   assign gey = (ry_ff >= dsh_ff);

   // emit candidate and duplicate filter
   crd_type cand_x, cand_y;
   logic    emit_go, emit_chk, emit_keep;
   always_comb begin
      cand_x   = ex_ff;
      cand_y   = ey_ff;
      emit_go  = 1'b0;
      emit_chk = 1'b1;
      if (cmd.op == OP_EMIT_PT) begin
         cand_x  = {~qx_ff[CB-1], qx_ff[CB-2:0]};
         cand_y  = {~qy_ff[CB-1], qy_ff[CB-2:0]};
         emit_go = 1'b1;
      end else if (cmd.op == OP_EMIT_END) begin
         emit_go  = 1'b1;
         emit_chk = (func_ff != FUNC_START);
      end
   end
   assign emit_keep = emit_go &&
      !(emit_chk && pen_valid_ff && cand_x == pen_x_ff && cand_y == pen_y_ff);

   // result register load
   logic out_load;
   assign out_load = (emit_keep || cmd.op == OP_FLUSH) && pend_valid_ff;

   // status to the sequencer
   logic [IW:0] i_next;
   assign i_next = {1'b0, i_ff} + 1'b1;
   assign status.is_cubic = cubic;
   assign status.cull = cfg_clip_en &&
      (bx_lo_ff > cfg_xhi || bx_hi_ff < cfg_xlo || by_lo_ff > cfg_yhi || by_hi_ff < cfg_ylo);
   assign status.div_done = div_done;
   assign status.pt_more  = (i_next < {1'b0, m_ff});
   assign status.out_free = !out_valid_ff || out_ready;

   // arithmetic registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            func_ff  <= in_func;
            p0x_ff   <= pen_x_ff;
            p0y_ff   <= pen_y_ff;
            p1x_ff   <= in_c1x;
            p1y_ff   <= in_c1y;
            p2x_ff   <= in_c2x;
            p2y_ff   <= in_c2y;
            ex_ff    <= in_ex;
            ey_ff    <= in_ey;
            bx_lo_ff <= pen_x_ff;
            bx_hi_ff <= pen_x_ff;
            by_lo_ff <= pen_y_ff;
            by_hi_ff <= pen_y_ff;
            len_ff   <= '0;
            q_ff     <= '0;
         end
         OP_GEOM: begin
            len_ff <= len_ff + len_add;
            if (cur_x < bx_lo_ff) bx_lo_ff <= cur_x;
            if (cur_x > bx_hi_ff) bx_hi_ff <= cur_x;
            if (cur_y < by_lo_ff) by_lo_ff <= cur_y;
            if (cur_y > by_hi_ff) by_hi_ff <= cur_y;
         end
         OP_DIV: if (!div_done) begin
            len_ff <= len_ff - LW'(cfg_spacing);
            q_ff   <= q_ff + 1'b1;
         end
         OP_MSET: begin
            m_ff <= (q_ff < CW'(3)) ? IW'(2) : IW'(q_ff - 1'b1);
            i_ff <= IW'(1);
         end
         OP_DEN1: sq_ff <= (2*IW)'(m_ff) * (2*IW)'(m_ff);
         OP_DEN2: den_ff <= cubic ? WW'(sq_ff) * WW'(m_ff) : WW'(sq_ff);
         OP_PTA: begin
            ss_ff <= (2*IW)'(s_v) * (2*IW)'(s_v);
            st_ff <= (2*IW)'(s_v) * (2*IW)'(i_ff);
            tt_ff <= (2*IW)'(i_ff) * (2*IW)'(i_ff);
         end
         OP_PTB: begin
            if (cubic) begin
               w_ff[0] <= WW'(ss_ff) * WW'(s_v);
               w_ff[1] <= WW'(3) * (WW'(ss_ff) * WW'(i_ff));
               w_ff[2] <= WW'(3) * (WW'(st_ff) * WW'(i_ff));
               w_ff[3] <= WW'(tt_ff) * WW'(i_ff);
            end else begin
               w_ff[0] <= WW'(ss_ff);
               w_ff[1] <= WW'(st_ff) << 1;
               w_ff[2] <= WW'(tt_ff);
               w_ff[3] <= '0;
            end
         end
         OP_MAC: begin
            accx_ff <= (cmd.sel == 2'd0) ? prodx : accx_ff + prodx;
            accy_ff <= (cmd.sel == 2'd0) ? prody : accy_ff + prody;
         end
         OP_PREP: begin
            // floor((2 num + den) / (2 den)) by shift and subtract
            rx_ff  <= {accx_ff, 1'b0} + NW'(den_ff);
            ry_ff  <= {accy_ff, 1'b0} + NW'(den_ff);
            dsh_ff <= NW'(den_ff) << CB;
            qx_ff  <= '0;
            qy_ff  <= '0;
         end
         OP_QBIT: begin
            if (gex) rx_ff <= rx_ff - dsh_ff;
            if (gey) ry_ff <= ry_ff - dsh_ff;
            qx_ff  <= {qx_ff[CB-2:0], gex};
            qy_ff  <= {qy_ff[CB-2:0], gey};
            dsh_ff <= dsh_ff >> 1;
         end
         OP_EMIT_PT: i_ff <= i_next[IW-1:0];
         default: ;
      endcase
   end

   // pen, pending vertex and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff      <= '0;
         pen_y_ff      <= '0;
         pen_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_load) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
         if (emit_keep) begin
            pen_x_ff      <= cand_x;
            pen_y_ff      <= cand_y;
            pen_valid_ff  <= 1'b1;
            pend_x_ff     <= cand_x;
            pend_y_ff     <= cand_y;
            pend_valid_ff <= 1'b1;
            if (pend_valid_ff) begin
               out_x_ff     <= pend_x_ff;
               out_y_ff     <= pend_y_ff;
               out_last_ff  <= 1'b0;
            end
         end else if (cmd.op == OP_FLUSH && pend_valid_ff) begin
            out_x_ff      <= pend_x_ff;
            out_y_ff      <= pend_y_ff;
            out_last_ff   <= 1'b1;
            pend_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_last  = out_last_ff;

   // result register is only loaded when free
   assert property (@(posedge clock) disable iff (reset)
      ((emit_keep && pend_valid_ff) || (cmd.op == OP_FLUSH && pend_valid_ff))
      |-> (!out_valid_ff || out_ready))
      else $error("result overwritten");

   // a segment always ends with nothing held back
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FLUSH) |=> !pend_valid_ff)
      else $error("vertex held after flush");

   // once a vertex is kept the pen stays valid
   assert property (@(posedge clock) disable iff (reset)
      pen_valid_ff |=> pen_valid_ff)
      else $error("pen lost");

   // interior points stay inside the curve
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT_PT) |-> (i_ff < m_ff && i_ff != '0))
      else $error("interior index out of range");

endmodule

`default_nettype wire

// ===== rtl/bezier_path_flattener_core.sv =====
// ---------------------------------------------------------------------------
// bezier_path_flattener_core: path segment to polyline vertex converter
// Register file, stream unpacking, sequencer and datapath.
// ---------------------------------------------------------------------------
// start and line segments: end vertex emission, then a flush that moves a kept end
//   vertex into the result register; both wait while the result register is full
// curves: geometry and bounding box, cull check, point count by subtraction,
//   setup, then per interior vertex weights, mac and a bit serial divider
// one segment is in work at a time; the next word is taken once the last
//   vertex of the current one sits in the result register
// synchronous active high reset: registers at defaults, pen at origin, no pen yet
`timescale 1ns / 1ps
`default_nettype none

module bezier_path_flattener_core #(
   parameter int MAX_SEG_POINTS = bpf_pkg::MAX_SEG_POINTS_DEF,
   parameter int COORD_BITS     = bpf_pkg::COORD_BITS_DEF,
   parameter int REQ_BITS       = ((2 + 6 * COORD_BITS + 7) / 8) * 8,
   parameter int RSP_BITS       = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // func, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [REQ_BITS-1:0]                req_tdata,
   // point_x, point_y
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [RSP_BITS-1:0]                     rsp_tdata,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bpf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [bpf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bpf_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);
   import bpf_pkg::*;

   localparam int CB = COORD_BITS;

   // configuration registers
   logic [7:0]          spacing_ff;
   logic                clip_en_ff;
   logic signed [CB-1:0] xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   reg_index_type       csr_idx;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_RESET;
         clip_en_ff <= 1'b0;
         xlo_ff     <= '0;
         xhi_ff     <= {1'b0, {(CB-1){1'b1}}};
         ylo_ff     <= '0;
         yhi_ff     <= {1'b0, {(CB-1){1'b1}}};
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SPACING:  spacing_ff <= csr_pwdata[7:0];
            REG_CLIP_EN:  clip_en_ff <= csr_pwdata[0];
            REG_CLIP_XLO: xlo_ff     <= csr_pwdata[CB-1:0];
            REG_CLIP_XHI: xhi_ff     <= csr_pwdata[CB-1:0];
            REG_CLIP_YLO: ylo_ff     <= csr_pwdata[CB-1:0];
            REG_CLIP_YHI: yhi_ff     <= csr_pwdata[CB-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_idx)
         REG_SPACING:  csr_prdata = CSR_DATA_BITS'(spacing_ff);
         REG_CLIP_EN:  csr_prdata = CSR_DATA_BITS'(clip_en_ff);
         REG_CLIP_XLO: csr_prdata = CSR_DATA_BITS'(unsigned'(xlo_ff));
         REG_CLIP_XHI: csr_prdata = CSR_DATA_BITS'(unsigned'(xhi_ff));
         REG_CLIP_YLO: csr_prdata = CSR_DATA_BITS'(unsigned'(ylo_ff));
         REG_CLIP_YHI: csr_prdata = CSR_DATA_BITS'(unsigned'(yhi_ff));
         default:      csr_prdata = '0;
      endcase
   end

   // sequencer and datapath
   cmd_type    cmd;
   status_type status;
   logic signed [CB-1:0] pt_x, pt_y;

   bpf_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tdata[1:0]),
      .status     (status),
      .cmd        (cmd)
   );

   bpf_datapath #(
      .MAX_SEG_POINTS (MAX_SEG_POINTS),
      .COORD_BITS     (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_func     (req_tdata[1:0]),
      .in_c1x      (req_tdata[2 +: CB]),
      .in_c1y      (req_tdata[2 + CB +: CB]),
      .in_c2x      (req_tdata[2 + 2*CB +: CB]),
      .in_c2y      (req_tdata[2 + 3*CB +: CB]),
      .in_ex       (req_tdata[2 + 4*CB +: CB]),
      .in_ey       (req_tdata[2 + 5*CB +: CB]),
      .cfg_spacing (spacing_ff),
      .cfg_clip_en (clip_en_ff),
      .cfg_xlo     (xlo_ff),
      .cfg_xhi     (xhi_ff),
      .cfg_ylo     (ylo_ff),
      .cfg_yhi     (yhi_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_x       (pt_x),
      .out_y       (pt_y),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = RSP_BITS'({pt_y, pt_x});

endmodule

`default_nettype wire
